// ===== rtl/slat_pkg.sv =====
// shared types and constants for the sorted address label table
package slat_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_BITS   = 24;

  localparam int unsigned IN_ADDR_W = 24;
  localparam int unsigned NAME_W    = 16;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W     = IDX_W + 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_OVERWRITTEN = 3'd1,
    ST_FOUND       = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_CHECK,
    S_SHRD,
    S_SHWR,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                  op;
    logic [IN_ADDR_W-1:0] addr;
    logic [NAME_W-1:0]    name_handle;
    logic                 generated;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  position;
    logic [NAME_W-1:0] found_name;
    logic              found_generated;
    logic [POS_W-1:0]  entry_total;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [NAME_W-1:0]    name;
    logic                 flag;
  } entry_t;

endpackage

// ===== rtl/slat_ram.sv =====
// generic simple dual port ram with registered read
module slat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sorted_address_label_table.sv =====
// sorted address label table: binary search and shifting insert over one entry ram
//
//   channel | dir | payload     | handshake
//   in      | in  | in_word_i   | in_valid_i / in_stall_o
//   out     | out | out_word_o  | out_valid_o / out_stall_i
//
// one word at a time; each word runs a binary search of halving steps (at most ceil(log2(count+1))),
// plus a read and a write per entry moved on a new insert, all set by the one-read one-write entry ram
// the result sits in an output register, so the next word is taken while it waits
// reset clears the entry count and the control; ram contents are never cleared
// a stalled output holds only the finish of the next word, not its search
module sorted_address_label_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slat_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slat_pkg::out_word_t out_word_o
);

  import slat_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [CNT_W-1:0]  sh_q, sh_d;
  in_word_t          req_q, req_d;
  out_word_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;

  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  sh_prev;
  logic [ADDR_BITS-1:0] key;
  entry_t            new_entry;
  logic              hit;
  logic              out_free;

  slat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign sh_prev   = sh_q - CNT_W'(1);
  assign key       = ADDR_BITS'(req_q.addr);
  assign new_entry = '{addr: key, name: req_q.name_handle, flag: req_q.generated};
  assign hit       = (lo_q < count_q) && (ram_rdata.addr == key);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    sh_d        = sh_q;
    req_d       = req_q;
    res_d       = res_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = lo_q[IDX_W-1:0];
    ram_wdata   = new_entry;
    ram_raddr   = lo_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_word_i;
          lo_d    = '0;
          hi_d    = count_q;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid[IDX_W-1:0];
          state_d   = S_CMP;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CMP: begin
        if (ram_rdata.addr < key) begin
          lo_d = mid + CNT_W'(1);
        end else begin
          hi_d = mid;
        end
        state_d = S_SRCH;
      end
      S_CHECK: begin
        res_d.position        = POS_W'(lo_q);
        res_d.found_name      = '0;
        res_d.found_generated = 1'b0;
        res_d.entry_total     = POS_W'(count_q);
        state_d               = S_DONE;
        if (req_q.op == OP_FIND) begin
          if (hit) begin
            res_d.status          = ST_FOUND;
            res_d.found_name      = ram_rdata.name;
            res_d.found_generated = ram_rdata.flag;
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end else if (hit) begin
          ram_we       = 1'b1;
          res_d.status = ST_OVERWRITTEN;
        end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
          res_d.status = ST_FULL;
        end else begin
          sh_d    = count_q;
          state_d = S_SHRD;
        end
      end
      S_SHRD: begin
        if (sh_q > lo_q) begin
          ram_raddr = sh_prev[IDX_W-1:0];
          state_d   = S_SHWR;
        end else begin
          ram_we            = 1'b1;
          count_d           = count_q + CNT_W'(1);
          res_d.status      = ST_INSERTED;
          res_d.entry_total = POS_W'(count_q + CNT_W'(1));
          state_d           = S_DONE;
        end
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_q[IDX_W-1:0];
        ram_wdata = ram_rdata;
        sh_d      = sh_prev;
        state_d   = S_SHRD;
      end
      S_DONE: begin
        if (out_free) begin
          out_word_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    sh_q       <= sh_d;
    req_q      <= req_d;
    res_q      <= res_d;
    out_word_q <= out_word_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH || state_q == S_CMP) |-> (lo_q <= hi_q && hi_q <= count_q))
    else $error("search window out of order");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHWR |-> (sh_q > lo_q && sh_q <= count_q))
    else $error("shift index outside moved range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> ($past(state_q == S_SHRD) && count_q == $past(count_q) + 1'b1))
    else $error("entry count changed outside an insert");

endmodule

// ===== bench/sorted_address_label_table_tb.sv =====
`timescale 1ns / 100ps
// testbench for the sorted address label table: directed and random words checked against a mirror
module sorted_address_label_table_tb;
  import slat_pkg::*;

  class label_table_mirror;
    logic [ADDR_BITS-1:0] key_a [TABLE_DEPTH];
    logic [NAME_W-1:0]    name_a [TABLE_DEPTH];
    logic                 flag_a [TABLE_DEPTH];
    int unsigned          held;
    out_word_t            due_q [$];
    int unsigned          errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function int unsigned lower_bound(logic [ADDR_BITS-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = held;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key_a[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void apply_request(in_word_t w);
      logic [ADDR_BITS-1:0] key;
      int unsigned          pos;
      bit                   hit;
      out_word_t            r;
      key = w.addr[ADDR_BITS-1:0];
      pos = lower_bound(key);
      hit = (pos < held) && (key_a[pos] == key);
      r = '0;
      r.position = pos[POS_W-1:0];
      if (w.op == OP_FIND) begin
        if (hit) begin
          r.status = ST_FOUND;
          r.found_name = name_a[pos];
          r.found_generated = flag_a[pos];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end else if (hit) begin
        name_a[pos] = w.name_handle;
        flag_a[pos] = w.generated;
        r.status = ST_OVERWRITTEN;
      end else if (held >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int unsigned i = held; i > pos; i--) begin
          key_a[i] = key_a[i-1];
          name_a[i] = name_a[i-1];
          flag_a[i] = flag_a[i-1];
        end
        key_a[pos] = key;
        name_a[pos] = w.name_handle;
        flag_a[pos] = w.generated;
        held++;
        r.status = ST_INSERTED;
      end
      r.entry_total = held[POS_W-1:0];
      due_q.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void match_result(out_word_t got);
      out_word_t want;
      if (due_q.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      compare("status", want.status, got.status);
      compare("position", want.position, got.position);
      compare("found_name", want.found_name, got.found_name);
      compare("found_generated", want.found_generated, got.found_generated);
      compare("entry_total", want.entry_total, got.entry_total);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  label_table_mirror    table_mirror = new();
  logic [IN_ADDR_W-1:0] used_q [$];
  bit                   quiet;
  bit                   held_off;
  int unsigned          words_checked;

  sorted_address_label_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic send_op(op_e op, logic [IN_ADDR_W-1:0] addr, logic [NAME_W-1:0] name,
                         logic gen);
    in_word_t w;
    w.op = op;
    w.addr = addr;
    w.name_handle = name;
    w.generated = gen;
    if (op == OP_INSERT) used_q.push_back(addr);
    in_word_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    table_mirror.apply_request(w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  function automatic logic [IN_ADDR_W-1:0] pick_addr();
    logic [IN_ADDR_W-1:0] a;
    int unsigned          sel;
    sel = $urandom_range(0, 9);
    a = IN_ADDR_W'($urandom);
    if (sel >= 5 && sel <= 8 && used_q.size() > 0) begin
      a = used_q[$urandom_range(0, used_q.size() - 1)];
      if (sel == 8) a = $urandom_range(0, 1) ? a + 1'b1 : a - 1'b1;
    end else if (sel == 9) begin
      a = IN_ADDR_W'($urandom_range(0, 7));
      if ($urandom_range(0, 1)) a = ~a;
    end
    return a;
  endfunction

  task automatic send_random(int unsigned n);
    logic [IN_ADDR_W-1:0] a;
    repeat (n) begin
      a = pick_addr();
      if ($urandom_range(0, 9) < 7) send_op(OP_INSERT, a, NAME_W'($urandom), 1'($urandom));
      else send_op(OP_FIND, a, NAME_W'($urandom), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, then keys above, below and between held entries
    send_op(OP_FIND, 24'h000000, 16'h0000, 1'b0);
    send_op(OP_INSERT, 24'h800000, 16'h1234, 1'b0);
    send_op(OP_FIND, 24'hffffff, 16'hffff, 1'b1);
    send_op(OP_INSERT, 24'hffffff, 16'hffff, 1'b1);
    send_op(OP_INSERT, 24'h000000, 16'h0000, 1'b1);
    send_op(OP_FIND, 24'h000000, 16'h0000, 1'b0);
    send_op(OP_FIND, 24'hffffff, 16'h0000, 1'b0);
    send_op(OP_INSERT, 24'h800000, 16'habcd, 1'b1);
    send_op(OP_FIND, 24'h800000, 16'h0000, 1'b0);
    send_op(OP_FIND, 24'h7fffff, 16'h0000, 1'b0);
    send_op(OP_FIND, 24'h800001, 16'h0000, 1'b0);
    send_op(OP_INSERT, 24'h555555, 16'h5555, 1'b0);
    send_op(OP_INSERT, 24'haaaaaa, 16'haaaa, 1'b1);
    send_op(OP_INSERT, 24'h000001, 16'h0001, 1'b0);
    send_op(OP_INSERT, 24'hfffffe, 16'hfffe, 1'b1);
    send_op(OP_FIND, 24'hfffffe, 16'h0000, 1'b0);
    send_op(OP_INSERT, 24'hffffff, 16'h0000, 1'b0);
    send_op(OP_FIND, 24'hffffff, 16'hffff, 1'b1);
    send_op(OP_FIND, 24'h555555, 16'h0000, 1'b0);

    send_random(590);

    // fill the table so that new addresses get refused
    while (table_mirror.held < TABLE_DEPTH) begin
      send_op(OP_INSERT, IN_ADDR_W'($urandom), NAME_W'($urandom), 1'($urandom));
    end

    quiet = 1'b1;
    send_random(40);
    in_valid_i <= 1'b0;

    while (table_mirror.due_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (table_mirror.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_drain
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        table_mirror.match_result(out_word_o);
        words_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!quiet && !held_off && words_checked >= 60) begin
        // long hold so the block backs up into its input
        held_off = 1'b1;
        hold_left = 300;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 9);
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
